FILE: design/ncl_pkg.sv
// Shared constants and types for the necklace counter.
`default_nettype none
package ncl_pkg;

    localparam int LEN_W = 21;
    localparam int COL_W = 30;
    localparam int SH_W  = 5;

    localparam logic [COL_W-1:0] PRIME   = 30'd1000000007;
    localparam logic [COL_W-1:0] INV_EXP = 30'd1000000005;   // prime - 2 (Fermat inverse)
    localparam logic [LEN_W-1:0] MAX_N   = 21'd1048576;

    // Job handed from the front end to the back end.
    typedef struct packed {
        logic             zero;   // result is 0 without any work
        logic [LEN_W-1:0] len;
        logic [COL_W-1:0] col;    // already reduced mod prime
    } job_t;

    typedef struct packed {
        logic             start;
        logic [COL_W-1:0] a;
        logic [COL_W-1:0] b;
    } mm_req_t;

    typedef struct packed {
        logic             done;
        logic [COL_W-1:0] res;
    } mm_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD_INIT,
        ST_GCD,
        ST_POW,
        ST_MUL_ACC,
        ST_MUL_SQR,
        ST_MUL_FIN,
        ST_OUT
    } back_state_t;

endpackage
`default_nettype wire

FILE: design/necklace_count_mod_prime.sv
// Top level of the necklace counter modulo 1000000007.
//
//  channel | dir | tdata bits (low first)                     | width
//  s_      | in  | necklace_length[20:0], colour_count[50:21] | 56
//  m_      | out | necklace_count[29:0]                       | 32
//
// An item of length n takes, per k in 0..n-1, a binary gcd plus a
// square-and-multiply power in which each modular product is issued and
// then waits on the multiplier, then the Fermat exponent p-2
// (29 squares and 15 multiplies, 44 products) and one final product. The
// bit-serial modular multiplier sets the pace. Zero or oversize lengths
// skip this work and give 0. Reset is synchronous, active low; the two-entry
// queue keeps taking items until full while a result waits on m_tready.
`default_nettype none
module necklace_count_mod_prime
    import ncl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // [20:0] necklace_length, [50:21] colour_count
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [29:0] necklace_count
);

    job_t    push_job, pop_job;
    logic    push, pop, full, empty;
    mm_req_t mm_req;
    mm_rsp_t mm_rsp;

    ncl_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (full),
        .q_push   (push),
        .q_job    (push_job)
    );

    ncl_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (empty)
    );

    ncl_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mm_req),
        .rsp     (mm_rsp)
    );

    ncl_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (empty),
        .q_job    (pop_job),
        .q_pop    (pop),
        .mm_req   (mm_req),
        .mm_rsp   (mm_rsp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

FILE: design/ncl_front.sv
// Front end: takes input items, reduces the colour count and flags trivial items.
`default_nettype none
module ncl_front
    import ncl_pkg::*;
(
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // [20:0] necklace_length, [50:21] colour_count
    input  wire logic        q_full,
    output logic             q_push,
    output job_t             q_job
);

    logic [LEN_W-1:0] len;
    logic [COL_W-1:0] col;

    assign len = s_tdata[LEN_W-1:0];
    assign col = s_tdata[LEN_W+COL_W-1:LEN_W];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_job.len  = len;
        q_job.zero = (len == '0) || (len > MAX_N);
        // colour count is below twice the prime, one subtract suffices
        q_job.col  = (col >= PRIME) ? (col - PRIME) : col;
    end

endmodule
`default_nettype wire

FILE: design/ncl_queue.sv
// Two-entry job queue between front and back end.
`default_nettype none
module ncl_queue
    import ncl_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  job_t      push_job,
    output logic      full,
    input  wire logic pop,
    output job_t      pop_job,
    output logic      empty
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign pop_job = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

FILE: design/ncl_mulmod.sv
// Bit-serial modular multiplier, one bit of b per cycle, MSB first.
`default_nettype none
module ncl_mulmod
    import ncl_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  mm_req_t   req,
    output mm_rsp_t   rsp
);

    logic [COL_W-1:0] a_reg, b_reg, acc_reg, acc_next;
    logic [SH_W-1:0]  cnt_reg;
    logic             busy_reg, done_reg;
    logic [COL_W:0]   dbl, dbl_r, sum, sum_r;

    always_comb begin
        dbl   = {acc_reg, 1'b0};
        dbl_r = (dbl >= {1'b0, PRIME}) ? (dbl - {1'b0, PRIME}) : dbl;
        sum   = dbl_r + (b_reg[COL_W-1] ? {1'b0, a_reg} : '0);
        sum_r = (sum >= {1'b0, PRIME}) ? (sum - {1'b0, PRIME}) : sum;
        acc_next = sum_r[COL_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == SH_W'(COL_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[COL_W-2:0], 1'b0};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = acc_reg;

endmodule
`default_nettype wire

FILE: design/ncl_back.sv
// Back end: gcd sum of colour powers, Fermat inverse of n, result register.
`default_nettype none
module ncl_back
    import ncl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_empty,
    input  job_t             q_job,
    output logic             q_pop,
    output mm_req_t          mm_req,
    input  mm_rsp_t          mm_rsp,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [29:0] necklace_count
);

    back_state_t      state_reg, state_next;
    logic [LEN_W-1:0] n_reg, n_next, k_reg, k_next;
    logic [LEN_W-1:0] ga_reg, ga_next, gb_reg, gb_next;
    logic [SH_W-1:0]  sh_reg, sh_next;
    logic [COL_W-1:0] m_reg, m_next, sum_reg, sum_next;
    logic [COL_W-1:0] acc_reg, acc_next, base_reg, base_next, exp_reg, exp_next;
    logic [COL_W-1:0] res_reg, res_next;
    logic             inv_reg, inv_next;
    logic [LEN_W-1:0] gcd_val;
    logic [COL_W:0]   add_raw;
    logic [COL_W-1:0] add_mod;

    always_comb begin
        gcd_val = ((ga_reg == '0) ? gb_reg : ga_reg) << sh_reg;
        add_raw = {1'b0, sum_reg} + {1'b0, acc_reg};
        add_mod = (add_raw >= {1'b0, PRIME}) ? COL_W'(add_raw - {1'b0, PRIME})
                                             : add_raw[COL_W-1:0];
    end

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        ga_next    = ga_reg;
        gb_next    = gb_reg;
        sh_next    = sh_reg;
        m_next     = m_reg;
        sum_next   = sum_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        exp_next   = exp_reg;
        res_next   = res_reg;
        inv_next   = inv_reg;
        q_pop      = 1'b0;
        mm_req     = '{start: 1'b0, a: acc_reg, b: base_reg};
        m_tvalid   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    inv_next = 1'b0;
                    if (q_job.zero) begin
                        res_next   = '0;
                        state_next = ST_OUT;
                    end else begin
                        n_next     = q_job.len;
                        m_next     = q_job.col;
                        k_next     = '0;
                        sum_next   = '0;
                        state_next = ST_GCD_INIT;
                    end
                end
            end
            ST_GCD_INIT: begin
                ga_next    = n_reg;
                gb_next    = k_reg;
                sh_next    = '0;
                state_next = ST_GCD;
            end
            ST_GCD: begin
                // binary gcd, one step a cycle
                if (ga_reg == '0 || gb_reg == '0) begin
                    exp_next   = {{(COL_W-LEN_W){1'b0}}, gcd_val};
                    base_next  = m_reg;
                    acc_next   = COL_W'(1);
                    state_next = ST_POW;
                end else if (!ga_reg[0] && !gb_reg[0]) begin
                    ga_next = ga_reg >> 1;
                    gb_next = gb_reg >> 1;
                    sh_next = sh_reg + 1'b1;
                end else if (!ga_reg[0]) begin
                    ga_next = ga_reg >> 1;
                end else if (!gb_reg[0]) begin
                    gb_next = gb_reg >> 1;
                end else if (ga_reg >= gb_reg) begin
                    ga_next = (ga_reg - gb_reg) >> 1;
                end else begin
                    gb_next = (gb_reg - ga_reg) >> 1;
                end
            end
            ST_POW: begin
                if (exp_reg == '0) begin
                    if (inv_reg) begin
                        mm_req     = '{start: 1'b1, a: sum_reg, b: acc_reg};
                        state_next = ST_MUL_FIN;
                    end else begin
                        sum_next = add_mod;
                        if (k_reg == n_reg - 1'b1) begin
                            // all terms summed: now n^(p-2)
                            inv_next  = 1'b1;
                            base_next = {{(COL_W-LEN_W){1'b0}}, n_reg};
                            exp_next  = INV_EXP;
                            acc_next  = COL_W'(1);
                        end else begin
                            k_next     = k_reg + 1'b1;
                            state_next = ST_GCD_INIT;
                        end
                    end
                end else if (exp_reg[0]) begin
                    mm_req     = '{start: 1'b1, a: acc_reg, b: base_reg};
                    state_next = ST_MUL_ACC;
                end else begin
                    mm_req     = '{start: 1'b1, a: base_reg, b: base_reg};
                    state_next = ST_MUL_SQR;
                end
            end
            ST_MUL_ACC: begin
                if (mm_rsp.done) begin
                    acc_next   = mm_rsp.res;
                    exp_next   = {exp_reg[COL_W-1:1], 1'b0};
                    state_next = ST_POW;
                end
            end
            ST_MUL_SQR: begin
                if (mm_rsp.done) begin
                    base_next  = mm_rsp.res;
                    exp_next   = exp_reg >> 1;
                    state_next = ST_POW;
                end
            end
            ST_MUL_FIN: begin
                if (mm_rsp.done) begin
                    res_next   = mm_rsp.res;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg    <= n_next;
        k_reg    <= k_next;
        ga_reg   <= ga_next;
        gb_reg   <= gb_next;
        sh_reg   <= sh_next;
        m_reg    <= m_next;
        sum_reg  <= sum_next;
        acc_reg  <= acc_next;
        base_reg <= base_next;
        exp_reg  <= exp_next;
        res_reg  <= res_next;
        inv_reg  <= inv_next;
    end

    assign m_tdata = {2'b00, res_reg};

endmodule
`default_nettype wire
